[rtl/abkf_pkg.sv]
// Package for the angle/bias Kalman filter: widths, fixed-point constants,
// register indexes and a saturation helper. No dependencies.
package abkf_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W = 17;
  localparam int ACC_W = 25;
  localparam int GYR_W = 28;
  localparam int DW = 32;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd3;

  localparam logic [CFG_W-1:0] RST_ANGLE_NOISE =
    CFG_W'(((64'd1 << FRAC_BITS) * 5 + 50) / 100);
  localparam logic [CFG_W-1:0] RST_BIAS_NOISE =
    CFG_W'(((64'd1 << FRAC_BITS) * 5 + 50) / 100);
  localparam logic [CFG_W-1:0] RST_MEASURE_NOISE =
    CFG_W'(((64'd1 << FRAC_BITS) * 6 + 50) / 100);
  localparam logic [CFG_W-1:0] RST_SAMPLE_PERIOD =
    CFG_W'(((64'd1 << FRAC_BITS) * 1 + 50) / 100);
  localparam logic signed [DW-1:0] ONE = DW'(64'd1 << FRAC_BITS);

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [DW-1:0] sat34(input logic signed [DW+1:0] v);
    if (v > 34'sh0_7FFF_FFFF) sat34 = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) sat34 = 32'sh8000_0000;
    else sat34 = v[DW-1:0];
  endfunction
endpackage

[rtl/abkf_div.sv]
// Radix-2 restoring signed divider: sat((num << FRAC_BITS) / den), truncated.
// Depends on abkf_pkg.
module abkf_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [abkf_pkg::DW-1:0] num,
  input  logic signed [abkf_pkg::DW-1:0] den,
  output logic busy,
  output logic signed [abkf_pkg::DW-1:0] quo
);
  localparam int NW = abkf_pkg::DW + abkf_pkg::FRAC_BITS;
  logic [NW-1:0] q_r, q_nxt;
  logic [abkf_pkg::DW:0] rem_r, rem_nxt, trial;
  logic [abkf_pkg::DW-1:0] d_r;
  logic neg_r;
  logic [5:0] cnt_r;
  logic signed [NW:0] sq;
  logic [NW-1:0] an;
  logic [abkf_pkg::DW-1:0] ad;

  assign an = num[abkf_pkg::DW-1] ? NW'(-{{abkf_pkg::FRAC_BITS{num[abkf_pkg::DW-1]}}, num})
              << abkf_pkg::FRAC_BITS >> abkf_pkg::FRAC_BITS << abkf_pkg::FRAC_BITS
            : NW'({{abkf_pkg::FRAC_BITS{1'b0}}, num}) << abkf_pkg::FRAC_BITS;
  assign ad = den[abkf_pkg::DW-1] ? -den : den;

  always_comb begin
    trial = {rem_r[abkf_pkg::DW-1:0], q_r[NW-1]};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = trial - {1'b0, d_r};
      q_nxt = {q_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt = {q_r[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      q_r <= an;
      rem_r <= '0;
      d_r <= ad;
      neg_r <= num[abkf_pkg::DW-1] ^ den[abkf_pkg::DW-1];
      cnt_r <= 6'(NW);
    end else if (cnt_r != 0) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign busy = (cnt_r != 0);
  assign sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  always_comb begin
    if (sq > $signed((NW+1)'(32'h7FFF_FFFF))) quo = 32'sh7FFF_FFFF;
    else if (sq < -$signed((NW+1)'(33'h0_8000_0000))) quo = 32'sh8000_0000;
    else quo = sq[abkf_pkg::DW-1:0];
  end
endmodule

[rtl/angle_bias_kalman_filter.sv]
// Two-state angle / gyro-bias Kalman filter, one axis, Q16.16 saturating.
// Depends on abkf_pkg and abkf_div. After an accepted input the sequencer runs
// 9 steps, two divider waits with one launch step between, 6 update steps and
// one output step; the update steps are skipped when the innovation variance
// is zero. in_stall is high while busy: no input is taken until idle again.
// Synchronous active-low reset restores default registers and state.
module angle_bias_kalman_filter (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [abkf_pkg::ACC_W-1:0] in_accel_angle,
  input  logic signed [abkf_pkg::GYR_W-1:0] in_gyro_rate,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [abkf_pkg::DW-1:0] out_angle_out,
  output logic signed [abkf_pkg::DW-1:0] out_bias_out,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [abkf_pkg::CFG_W-1:0] cfg_wdata
);
  localparam int DW = abkf_pkg::DW;
  localparam int FB = abkf_pkg::FRAC_BITS;
  // Sequencer steps: each does at most one multiply-and-accumulate.
  localparam logic [4:0] S_IDLE = 5'd0, S_RATE = 5'd1, S_ANG = 5'd2, S_D0 = 5'd3,
    S_PAA = 5'd4, S_PAB = 5'd5, S_PBA = 5'd6, S_PBB = 5'd7, S_ERR = 5'd8,
    S_DIV0 = 5'd9, S_W0 = 5'd10, S_DIV1 = 5'd11, S_W1 = 5'd12, S_UAA = 5'd13,
    S_UAB = 5'd14, S_UBA = 5'd15, S_UBB = 5'd16, S_UANG = 5'd17, S_UBIAS = 5'd18,
    S_OUT = 5'd19;

  logic [abkf_pkg::CFG_W-1:0] qa_r, qb_r, rm_r, dt_r;
  logic signed [DW-1:0] ang_r, bias_r, paa_r, pab_r, pba_r, pbb_r;
  logic signed [DW-1:0] rate_r, d0_r, err_r, k0_r, t0_r, t1_r;
  logic signed [DW-1:0] accel_r, gyro_r;
  logic [4:0] st_r;
  logic signed [DW-1:0] quo;

  // Shared unit: acc +/- round(a*b >> FB), each part saturated.
  logic signed [DW-1:0] ma, mb, macc, mres, fm;
  logic msub;
  logic signed [2*DW-1:0] prod;
  logic signed [2*DW-1:0] psh;
  always_comb begin
    ma = '0; mb = '0; macc = '0; msub = 1'b0;
    unique case (st_r)
      S_ANG:   begin ma = rate_r; mb = DW'(dt_r); macc = ang_r; end
      S_PAA:   begin ma = d0_r; mb = DW'(dt_r); macc = paa_r; end
      S_PAB:   begin ma = d0_r; mb = DW'(dt_r); macc = pab_r; end
      S_PBA:   begin ma = d0_r; mb = DW'(dt_r); macc = pba_r; end
      S_PBB:   begin ma = DW'(qb_r); mb = DW'(dt_r); macc = pbb_r; end
      S_UAA:   begin ma = k0_r; mb = t0_r; macc = paa_r; msub = 1'b1; end
      S_UAB:   begin ma = k0_r; mb = t1_r; macc = pab_r; msub = 1'b1; end
      S_UBA:   begin ma = quo; mb = t0_r; macc = pba_r; msub = 1'b1; end
      S_UBB:   begin ma = quo; mb = t1_r; macc = pbb_r; msub = 1'b1; end
      S_UANG:  begin ma = k0_r; mb = err_r; macc = ang_r; end
      S_UBIAS: begin ma = quo; mb = err_r; macc = bias_r; end
      default: ;
    endcase
  end
  assign prod = ma * mb + (64'sd1 <<< (FB - 1));
  assign psh = prod >>> FB;
  always_comb begin
    if (psh > 64'sh7FFF_FFFF) fm = 32'sh7FFF_FFFF;
    else if (psh < -64'sh8000_0000) fm = 32'sh8000_0000;
    else fm = psh[DW-1:0];
  end
  assign mres = abkf_pkg::sat34(msub ? 34'(macc) - 34'(fm) : 34'(macc) + 34'(fm));

  // Divider, shared by both gains; k1 stays on its output until the end.
  logic dstart, dbusy;
  logic signed [DW-1:0] dnum, dden;
  assign dden = abkf_pkg::sat34(34'(rm_r) + 34'(paa_r));
  assign dnum = (st_r == S_DIV0) ? paa_r : pba_r;
  assign dstart = (st_r == S_DIV0 || st_r == S_DIV1) && (dden != 0);
  // Zero innovation variance gives zero gains.
  logic dzero_r;
  abkf_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                  .busy(dbusy), .quo(quo));
  logic signed [DW-1:0] gain;
  assign gain = dzero_r ? '0 : quo;

  assign in_stall = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0;
      qa_r <= abkf_pkg::RST_ANGLE_NOISE; qb_r <= abkf_pkg::RST_BIAS_NOISE;
      rm_r <= abkf_pkg::RST_MEASURE_NOISE; dt_r <= abkf_pkg::RST_SAMPLE_PERIOD;
      ang_r <= '0; bias_r <= '0; paa_r <= abkf_pkg::ONE; pab_r <= '0;
      pba_r <= '0; pbb_r <= abkf_pkg::ONE; dzero_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          abkf_pkg::REG_ANGLE_NOISE:   qa_r <= cfg_wdata;
          abkf_pkg::REG_BIAS_NOISE:    qb_r <= cfg_wdata;
          abkf_pkg::REG_MEASURE_NOISE: rm_r <= cfg_wdata;
          abkf_pkg::REG_SAMPLE_PERIOD: dt_r <= cfg_wdata;
          default: ;
        endcase
      end
      // Load a new result when the output register is free or drains now.
      if (st_r == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          accel_r <= DW'(in_accel_angle); gyro_r <= DW'(in_gyro_rate); st_r <= S_RATE;
        end
        S_RATE: begin
          rate_r <= abkf_pkg::sat34(34'(gyro_r) - 34'(bias_r)); st_r <= S_ANG;
        end
        S_ANG: begin ang_r <= mres; st_r <= S_D0; end
        S_D0: begin
          d0_r <= abkf_pkg::sat34(34'(qa_r) - 34'(pab_r) - 34'(pba_r)); st_r <= S_PAA;
        end
        S_PAA: begin
          paa_r <= mres;
          d0_r <= abkf_pkg::sat34(-34'(pbb_r)); st_r <= S_PAB;
        end
        S_PAB: begin pab_r <= mres; st_r <= S_PBA; end
        S_PBA: begin pba_r <= mres; st_r <= S_PBB; end
        S_PBB: begin pbb_r <= mres; st_r <= S_ERR; end
        S_ERR: begin
          err_r <= abkf_pkg::sat34(34'(accel_r) - 34'(ang_r));
          t0_r <= paa_r; t1_r <= pab_r; st_r <= S_DIV0;
        end
        S_DIV0: begin dzero_r <= (dden == 0); st_r <= S_W0; end
        S_W0: if (!dbusy) begin k0_r <= gain; st_r <= S_DIV1; end
        S_DIV1: st_r <= S_W1;
        S_W1: if (!dbusy) begin
          st_r <= dzero_r ? S_OUT : S_UAA;
        end
        S_UAA: begin paa_r <= mres; st_r <= S_UAB; end
        S_UAB: begin pab_r <= mres; st_r <= S_UBA; end
        S_UBA: begin pba_r <= mres; st_r <= S_UBB; end
        S_UBB: begin pbb_r <= mres; st_r <= S_UANG; end
        S_UANG: begin ang_r <= mres; st_r <= S_UBIAS; end
        S_UBIAS: begin bias_r <= mres; st_r <= S_OUT; end
        S_OUT: if (!out_valid || !out_stall) begin
          out_angle_out <= ang_r; out_bias_out <= bias_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_div_done_before_use: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_UAA) |-> !dbusy) else $error("gain used before divide done");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == S_OUT)) else $error("stray result");
endmodule
